// ----- rtl/cbpe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier point evaluation core.
// Used by cbpe_lerp and cubic_bezier_point_eval_core; depends on nothing.
package cbpe_pkg;

    // Chunk width of the signed operand in the split multipliers.
    localparam int MUL_CHUNK = 24;

    // Width of the pressure fields, unsigned Q4.12.
    localparam int PRESSURE_WIDTH = 16;

    // Number of register stages inside one interpolation level.
    localparam int LERP_STAGES = 3;

    // Register enables for the stages of one interpolation level, first stage in bit 0.
    typedef logic [LERP_STAGES-1:0] t_stage_en;

endpackage

// ----- rtl/cubic_bezier_point_eval_core.sv -----
`timescale 1ns / 1ps
// Cubic Bezier point, pressure and slope evaluator, top level.
// Depends on cbpe_pkg and cbpe_lerp.
//
// Each transaction carries four control points, two end pressures and a curve
// parameter t (clamped to 1.0). The core evaluates the curve by de Casteljau's
// scheme in exact fixed point. The pipeline has eleven register stages: an input
// register, three interpolation levels of three stages each, and one rounding
// stage. A new transaction is accepted every cycle while the input is not stalled;
// the output register and the per-stage valid bits let the pipeline keep
// filling bubbles while a finished result waits. The point is rounded to
// nearest (ties toward plus infinity) from the last level, the slope is three
// times the difference of the two second-level values, rounded and clamped to
// +-3*2^COORD_WIDTH, and the pressure is interpolated linearly in t.
module cubic_bezier_point_eval_core
    import cbpe_pkg::*;
#(
    parameter int COORD_WIDTH     = 20,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl1_x,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl1_y,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl2_x,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl2_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic [PRESSURE_WIDTH-1:0]     i_start_pressure,
    input  logic [PRESSURE_WIDTH-1:0]     i_end_pressure,
    input  logic [PARAM_FRAC_BITS:0]      i_curve_param,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic [PRESSURE_WIDTH-1:0]     o_point_pressure,
    output logic signed [COORD_WIDTH+2:0] o_slope_x,
    output logic signed [COORD_WIDTH+2:0] o_slope_y
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = PARAM_FRAC_BITS;
    localparam int TW   = F + 1;
    localparam int SW   = W + 3;
    localparam int PSW  = PRESSURE_WIDTH;
    localparam int NS   = 4 * LERP_STAGES - 1;
    localparam int L1   = 1;
    localparam int L2   = L1 + LERP_STAGES;
    localparam int L3   = L2 + LERP_STAGES;
    localparam int SO   = L3 + LERP_STAGES;
    localparam int PNTW = W + 3 * F + 1;
    localparam int DW   = W + 2 * F + 1;
    localparam int D3W  = DW + 2;
    localparam int PPW  = TW + PSW;

    localparam logic [TW-1:0]         T_ONE   = TW'(1) << F;
    localparam logic signed [D3W-1:0] SLP_LIM = D3W'(3) << W;
    localparam logic signed [SW-1:0]  SLP_OUT = SW'(3) << W;

    logic [NS-1:0]             w_en;
    logic [NS-1:0]             r_vld;
    logic signed [W-1:0]       w_pt [2][4];
    logic signed [W-1:0]       r_pt [2][4];
    logic [TW-1:0]             n_t;
    logic [TW-1:0]             n_u;
    logic [TW-1:0]             r_t [L3];
    logic [TW-1:0]             r_u [L3];
    logic signed [W+F-1:0]     w_q [2][3];
    logic signed [W+2*F-1:0]   w_r [2][2];
    logic signed [W+3*F-1:0]   w_s [2];
    logic signed [W-1:0]       n_pnt [2];
    logic signed [W-1:0]       r_pnt [2];
    logic signed [SW-1:0]      n_slp [2];
    logic signed [SW-1:0]      r_slp [LERP_STAGES][2];
    logic signed [SW-1:0]      r_slo [2];
    logic [PSW-1:0]            r_ps;
    logic [PSW-1:0]            r_pe;
    logic [PPW-1:0]            w_ppu;
    logic [PPW-1:0]            w_ppe;
    logic [PPW-1:0]            r_ppu;
    logic [PPW-1:0]            r_ppe;
    logic [PSW-1:0]            n_prs;
    logic [PSW-1:0]            r_prs [L1+1:SO];

    // Stage enables: a stage loads when it is empty or the next stage moves on.
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NS-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Gather the control points per axis.
    assign w_pt[0][0] = i_start_x;
    assign w_pt[1][0] = i_start_y;
    assign w_pt[0][1] = i_ctrl1_x;
    assign w_pt[1][1] = i_ctrl1_y;
    assign w_pt[0][2] = i_ctrl2_x;
    assign w_pt[1][2] = i_ctrl2_y;
    assign w_pt[0][3] = i_end_x;
    assign w_pt[1][3] = i_end_y;

    // Clamp t to 1.0 and form u = 1 - t.
    always_comb begin
        n_t = (i_curve_param > T_ONE) ? T_ONE : i_curve_param;
        n_u = T_ONE - n_t;
    end

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_t[0] <= n_t;
            r_u[0] <= n_u;
            r_pt   <= w_pt;
            r_ps   <= i_start_pressure;
            r_pe   <= i_end_pressure;
        end
    end

    // t and u follow the data to the start of the second and third levels.
    always_ff @(posedge i_clk) begin
        for (int k = 1; k < L3; k++) begin
            if (w_en[k]) begin
                r_t[k] <= r_t[k-1];
                r_u[k] <= r_u[k-1];
            end
        end
    end

    // Three de Casteljau levels per axis, each value scaled by a further 2^F.
    for (genvar gx = 0; gx < 2; gx++) begin : g_axis
        for (genvar gi = 0; gi < 3; gi++) begin : g_lvl1
            cbpe_lerp #(.AW(W), .TW(TW)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_en[L2-1:L1]),
                .i_u   (r_u[0]),
                .i_t   (r_t[0]),
                .i_a   (r_pt[gx][gi]),
                .i_b   (r_pt[gx][gi+1]),
                .o_y   (w_q[gx][gi])
            );
        end
        for (genvar gi = 0; gi < 2; gi++) begin : g_lvl2
            cbpe_lerp #(.AW(W + F), .TW(TW)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_en[L3-1:L2]),
                .i_u   (r_u[L2-1]),
                .i_t   (r_t[L2-1]),
                .i_a   (w_q[gx][gi]),
                .i_b   (w_q[gx][gi+1]),
                .o_y   (w_r[gx][gi])
            );
        end
        cbpe_lerp #(.AW(W + 2 * F), .TW(TW)) u_lvl3 (
            .i_clk (i_clk),
            .i_en  (w_en[SO-1:L3]),
            .i_u   (r_u[L3-1]),
            .i_t   (r_t[L3-1]),
            .i_a   (w_r[gx][0]),
            .i_b   (w_r[gx][1]),
            .o_y   (w_s[gx])
        );

        // Slope: 3 * (r1 - r0), rounded at 2^(2F) and clamped.
        logic signed [DW-1:0]  w_d;
        logic signed [D3W-1:0] w_d3;
        logic signed [D3W-1:0] w_dsh;
        assign w_d   = DW'(w_r[gx][1]) - DW'(w_r[gx][0]);
        assign w_d3  = D3W'(w_d) + (D3W'(w_d) <<< 1) + (D3W'(1) << (2 * F - 1));
        assign w_dsh = w_d3 >>> (2 * F);
        always_comb begin
            if (w_dsh > SLP_LIM) begin
                n_slp[gx] = SW'(SLP_LIM);
            end else if (w_dsh < -SLP_LIM) begin
                n_slp[gx] = SW'(-SLP_LIM);
            end else begin
                n_slp[gx] = SW'(w_dsh);
            end
        end

        // Point: round the third level at 2^(3F).
        logic signed [PNTW-1:0] w_sr;
        assign w_sr       = PNTW'(w_s[gx]) + (PNTW'(1) << (3 * F - 1));
        assign n_pnt[gx]  = W'(w_sr >>> (3 * F));
    end

    // Slope is known after the second level and waits for the point.
    always_ff @(posedge i_clk) begin
        if (w_en[L3]) begin
            r_slp[0] <= n_slp;
        end
        for (int k = 1; k < LERP_STAGES; k++) begin
            if (w_en[L3+k]) begin
                r_slp[k] <= r_slp[k-1];
            end
        end
    end

    // Pressure: products in the first stage, rounded sum in the second.
    assign w_ppu = r_u[0] * r_ps;
    assign w_ppe = r_t[0] * r_pe;
    assign n_prs = PSW'((PPW'(r_ppu) + PPW'(r_ppe) + (PPW'(1) << (F - 1))) >> F);

    always_ff @(posedge i_clk) begin
        if (w_en[L1]) begin
            r_ppu <= w_ppu;
            r_ppe <= w_ppe;
        end
        if (w_en[L1+1]) begin
            r_prs[L1+1] <= n_prs;
        end
        for (int k = L1 + 2; k <= SO; k++) begin
            if (w_en[k]) begin
                r_prs[k] <= r_prs[k-1];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en[SO]) begin
            r_pnt <= n_pnt;
            r_slo <= r_slp[LERP_STAGES-1];
        end
    end

    assign o_point_x        = r_pnt[0];
    assign o_point_y        = r_pnt[1];
    assign o_point_pressure = r_prs[SO];
    assign o_slope_x        = r_slo[0];
    assign o_slope_y        = r_slo[1];

    // A full pipeline with a stalled output must hold off the input side.
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && i_stall) |-> o_stall)
        else $error("full pipeline accepted a transaction under output stall");

    // A held transaction in the input stage is never dropped.
    a_hold_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !w_en[0]) |=> r_vld[0])
        else $error("held transaction lost in the input stage");

    // The slope never leaves its clamp range.
    a_slope_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slope_x <= SLP_OUT && o_slope_x >= -SLP_OUT &&
                     o_slope_y <= SLP_OUT && o_slope_y >= -SLP_OUT))
        else $error("slope result outside its clamp range");

    // Reset empties the pipeline.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ----- rtl/cbpe_lerp.sv -----
`timescale 1ns / 1ps
// One exact interpolation step u*a + t*b with u + t = 2^F, three register stages.
// Depends on cbpe_pkg for the chunk width and the stage enable type.
module cbpe_lerp
    import cbpe_pkg::*;
#(
    parameter int AW = 20,
    parameter int TW = 17
) (
    input  logic                    i_clk,
    input  t_stage_en               i_en,
    input  logic [TW-1:0]           i_u,
    input  logic [TW-1:0]           i_t,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [AW-1:0]    i_b,
    output logic signed [AW+TW-2:0] o_y
);

    localparam int NCH  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW   = NCH * MUL_CHUNK;
    localparam int PPW  = MUL_CHUNK + TW + 2;
    localparam int SUMW = PW + TW + 2;
    localparam int YW   = AW + TW - 1;

    logic signed [PW-1:0]   w_ax;
    logic signed [PW-1:0]   w_bx;
    logic signed [PPW-1:0]  w_ppa [NCH];
    logic signed [PPW-1:0]  w_ppb [NCH];
    logic signed [PPW-1:0]  r_ppa [NCH];
    logic signed [PPW-1:0]  r_ppb [NCH];
    logic signed [SUMW-1:0] n_suma;
    logic signed [SUMW-1:0] n_sumb;
    logic signed [SUMW-1:0] r_suma;
    logic signed [SUMW-1:0] r_sumb;
    logic signed [YW-1:0]   r_y;

    // Sign-extend both operands to a whole number of chunks.
    assign w_ax = PW'(i_a);
    assign w_bx = PW'(i_b);

    // Partial products: the lower chunks are unsigned, the top chunk carries the sign.
    for (genvar k = 0; k < NCH; k++) begin : g_chunk
        logic signed [MUL_CHUNK:0] w_ca;
        logic signed [MUL_CHUNK:0] w_cb;
        if (k == NCH - 1) begin : g_top
            assign w_ca = {w_ax[PW-1], w_ax[k*MUL_CHUNK +: MUL_CHUNK]};
            assign w_cb = {w_bx[PW-1], w_bx[k*MUL_CHUNK +: MUL_CHUNK]};
        end else begin : g_low
            assign w_ca = {1'b0, w_ax[k*MUL_CHUNK +: MUL_CHUNK]};
            assign w_cb = {1'b0, w_bx[k*MUL_CHUNK +: MUL_CHUNK]};
        end
        assign w_ppa[k] = w_ca * $signed({1'b0, i_u});
        assign w_ppb[k] = w_cb * $signed({1'b0, i_t});
    end

    // First stage: register the partial products.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ppa <= w_ppa;
            r_ppb <= w_ppb;
        end
    end

    // Shift the partial products into place and add them up, one sum per operand.
    always_comb begin
        n_suma = '0;
        n_sumb = '0;
        for (int k = 0; k < NCH; k++) begin
            n_suma = n_suma + (SUMW'(r_ppa[k]) <<< (k * MUL_CHUNK));
            n_sumb = n_sumb + (SUMW'(r_ppb[k]) <<< (k * MUL_CHUNK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_suma <= n_suma;
            r_sumb <= n_sumb;
        end
    end

    // Third stage: the weights sum to 2^F, so the result fits AW+F bits.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_y <= YW'(r_suma + r_sumb);
        end
    end

    assign o_y = r_y;

endmodule

// ----- dv/cubic_bezier_point_eval_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_point_eval_core: directed corner cases, then
// random transactions under shifting idle patterns. Depends on cbpe_pkg and the core RTL.
module cubic_bezier_point_eval_core_tb;
    import cbpe_pkg::*;

    localparam int CW = 20;
    localparam int PF = 16;
    localparam int PW = PRESSURE_WIDTH;
    localparam int SW = CW + 3;
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -(1 << (CW - 1));
    localparam int ONE_T = 1 << PF;
    localparam int PMAX = (1 << PW) - 1;
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic signed [CW-1:0] start_x, start_y, ctrl1_x, ctrl1_y;
        logic signed [CW-1:0] ctrl2_x, ctrl2_y, end_x, end_y;
        logic [PW-1:0]        start_pressure, end_pressure;
        logic [PF:0]          curve_param;
    } t_bezier_item;

    typedef struct {
        logic signed [CW-1:0] point_x, point_y;
        logic [PW-1:0]        point_pressure;
        logic signed [SW-1:0] slope_x, slope_y;
    } t_bezier_result;

    // Holds the predicted curve results in acceptance order and checks arrivals.
    class t_bezier_expectations;
        t_bezier_result awaiting[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        // Coordinate moved up by half the range, so it is never negative.
        function logic [CW-1:0] offset_coord(logic signed [CW-1:0] v);
            return {~v[CW-1], v[CW-2:0]};
        endfunction

        // Difference a - b moved up by the full coordinate range.
        function logic [CW+1:0] offset_step(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
            longint d;
            d = longint'(a) - longint'(b) + (longint'(1) << CW);
            return d[CW+1:0];
        endfunction

        // Bernstein sum formed exactly, then rounded once with ties upward.
        function logic signed [CW-1:0] bernstein_point(logic [PF:0] u, logic [PF:0] t,
                logic signed [CW-1:0] p0, logic signed [CW-1:0] p1,
                logic signed [CW-1:0] p2, logic signed [CW-1:0] p3);
            logic [127:0] acc, b0, b1, b2, b3;
            b0 = offset_coord(p0);
            b1 = offset_coord(p1);
            b2 = offset_coord(p2);
            b3 = offset_coord(p3);
            acc = 128'(u) * u * u * b0 + 128'd3 * u * u * t * b1
                + 128'd3 * u * t * t * b2 + 128'(t) * t * t * b3;
            acc = acc + (128'd1 << (3 * PF - 1));
            acc = (acc >> (3 * PF)) - (128'd1 << (CW - 1));
            return acc[CW-1:0];
        endfunction

        // Derivative of the curve, rounded and clamped to +-3 * 2^CW.
        function logic signed [SW-1:0] bernstein_slope(logic [PF:0] u, logic [PF:0] t,
                logic signed [CW-1:0] p0, logic signed [CW-1:0] p1,
                logic signed [CW-1:0] p2, logic signed [CW-1:0] p3);
            logic [127:0] acc, d1, d2, d3;
            longint       lim, r;
            d1 = offset_step(p1, p0);
            d2 = offset_step(p2, p1);
            d3 = offset_step(p3, p2);
            acc = 128'd3 * u * u * d1 + 128'd6 * u * t * d2 + 128'd3 * t * t * d3
                + (128'd1 << (2 * PF - 1));
            acc = acc >> (2 * PF);
            // The weights sum to three, so the offset left after the shift is 3 * 2^CW.
            lim = 3 * (longint'(1) << CW);
            r = longint'(acc[63:0]) - lim;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r[SW-1:0];
        endfunction

        function logic [PW-1:0] blended_pressure(logic [PF:0] u, logic [PF:0] t,
                logic [PW-1:0] ps, logic [PW-1:0] pe);
            logic [63:0] s;
            s = 64'(u) * ps + 64'(t) * pe + (64'd1 << (PF - 1));
            return s[PF +: PW];
        endfunction

        // Works out the result of one accepted transaction and queues it.
        function void note_input(t_bezier_item it);
            logic [PF:0]    t, u;
            t_bezier_result r;
            // A parameter above one is treated as one.
            t = (it.curve_param > ONE_T) ? (PF+1)'(ONE_T) : it.curve_param;
            u = (PF+1)'(ONE_T) - t;
            r.point_x = bernstein_point(u, t, it.start_x, it.ctrl1_x, it.ctrl2_x, it.end_x);
            r.point_y = bernstein_point(u, t, it.start_y, it.ctrl1_y, it.ctrl2_y, it.end_y);
            r.point_pressure = blended_pressure(u, t, it.start_pressure, it.end_pressure);
            r.slope_x = bernstein_slope(u, t, it.start_x, it.ctrl1_x, it.ctrl2_x, it.end_x);
            r.slope_y = bernstein_slope(u, t, it.start_y, it.ctrl1_y, it.ctrl2_y, it.end_y);
            awaiting = {awaiting, r};
        endfunction

        function bit field_differs(string name, longint want, longint got);
            if (want == got) return 0;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            return 1;
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(t_bezier_result got);
            t_bezier_result want;
            bit             bad;
            if (awaiting.size() == 0) begin
                $error("result arrived with no transaction outstanding");
                errors++;
                return;
            end
            want = awaiting.pop_front();
            bad = 0;
            bad |= field_differs("point_x", longint'(want.point_x), longint'(got.point_x));
            bad |= field_differs("point_y", longint'(want.point_y), longint'(got.point_y));
            bad |= field_differs("point_pressure", longint'(want.point_pressure),
                                 longint'(got.point_pressure));
            bad |= field_differs("slope_x", longint'(want.slope_x), longint'(got.slope_x));
            bad |= field_differs("slope_y", longint'(want.slope_y), longint'(got.slope_y));
            if (bad) begin
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [CW-1:0] i_start_x, i_start_y, i_ctrl1_x, i_ctrl1_y;
    logic signed [CW-1:0] i_ctrl2_x, i_ctrl2_y, i_end_x, i_end_y;
    logic [PW-1:0]        i_start_pressure, i_end_pressure;
    logic [PF:0]          i_curve_param;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [CW-1:0] o_point_x, o_point_y;
    logic [PW-1:0]        o_point_pressure;
    logic signed [SW-1:0] o_slope_x, o_slope_y;

    t_bezier_expectations expected_points;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_asks;
    int                   hold_served;
    int                   hold_left;

    cubic_bezier_point_eval_core #(
        .COORD_WIDTH(CW),
        .PARAM_FRAC_BITS(PF)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_ctrl1_x(i_ctrl1_x),
        .i_ctrl1_y(i_ctrl1_y),
        .i_ctrl2_x(i_ctrl2_x),
        .i_ctrl2_y(i_ctrl2_y),
        .i_end_x(i_end_x),
        .i_end_y(i_end_y),
        .i_start_pressure(i_start_pressure),
        .i_end_pressure(i_end_pressure),
        .i_curve_param(i_curve_param),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_point_x(o_point_x),
        .o_point_y(o_point_y),
        .o_point_pressure(o_point_pressure),
        .o_slope_x(o_slope_x),
        .o_slope_y(o_slope_y)
    );

    always #1 i_clk = ~i_clk;

    // Run limit, far beyond the slowest correct run.
    initial begin
        #400000;
        $display("FAIL cubic_bezier_point_eval_core");
        $finish;
    end

    // Result side: check each accepted result, then pick the next stall value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            expected_points.check_result('{o_point_x, o_point_y, o_point_pressure,
                                           o_slope_x, o_slope_y});
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_asks != hold_served) begin
            // Long hold-off so the pipeline fills and backs up into the input.
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_bezier_item make_item(int sx, int sy, int c1x, int c1y,
            int c2x, int c2y, int ex, int ey, int ps, int pe, int cp);
        t_bezier_item it;
        it.start_x = sx[CW-1:0];
        it.start_y = sy[CW-1:0];
        it.ctrl1_x = c1x[CW-1:0];
        it.ctrl1_y = c1y[CW-1:0];
        it.ctrl2_x = c2x[CW-1:0];
        it.ctrl2_y = c2y[CW-1:0];
        it.end_x = ex[CW-1:0];
        it.end_y = ey[CW-1:0];
        it.start_pressure = ps[PW-1:0];
        it.end_pressure = pe[PW-1:0];
        it.curve_param = cp[PF:0];
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(9))
            0: return CMIN;
            1: return CMAX;
            2, 3: return $urandom_range(128) - 64;
            default: return int'($signed(20'($urandom())));
        endcase
    endfunction

    function automatic int rand_pressure();
        case ($urandom_range(7))
            0: return 0;
            1: return PMAX;
            default: return $urandom_range(PMAX);
        endcase
    endfunction

    function automatic int rand_param();
        case ($urandom_range(9))
            0: return 0;
            1: return ONE_T;
            2: return $urandom_range(2 * ONE_T - 1, ONE_T + 1);
            3: return $urandom_range(255);
            4: return ONE_T - $urandom_range(255);
            default: return $urandom_range(ONE_T);
        endcase
    endfunction

    // Offers one transaction, after an optional idle gap, and waits until it is taken.
    task automatic send_item(input t_bezier_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_start_x <= it.start_x;
        i_start_y <= it.start_y;
        i_ctrl1_x <= it.ctrl1_x;
        i_ctrl1_y <= it.ctrl1_y;
        i_ctrl2_x <= it.ctrl2_x;
        i_ctrl2_y <= it.ctrl2_y;
        i_end_x <= it.end_x;
        i_end_y <= it.end_y;
        i_start_pressure <= it.start_pressure;
        i_end_pressure <= it.end_pressure;
        i_curve_param <= it.curve_param;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_points.note_input(it);
    endtask

    // Stops offering until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_points.awaiting.size() != 0);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_item(make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                rand_pressure(), rand_pressure(), rand_param()));
    endtask

    initial begin
        expected_points = new();
        hold_asks = 0;
        hold_served = 0;
        hold_left = 0;
        send_idle_pct = 17;
        recv_idle_pct <= 50;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_start_x <= '0;
        i_start_y <= '0;
        i_ctrl1_x <= '0;
        i_ctrl1_y <= '0;
        i_ctrl2_x <= '0;
        i_ctrl2_y <= '0;
        i_end_x <= '0;
        i_end_y <= '0;
        i_start_pressure <= '0;
        i_end_pressure <= '0;
        i_curve_param <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: extreme coordinates and pressures, both ends of t,
        // parameters beyond one, and rounding ties in point, pressure and slope.
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, PMAX, 0));
        send_item(make_item(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, PMAX, 0, ONE_T));
        send_item(make_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                            PMAX, PMAX, ONE_T / 2));
        send_item(make_item(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 0, 0, 0));
        send_item(make_item(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 1, 2, ONE_T));
        send_item(make_item(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN,
                            PMAX, 0, ONE_T / 2));
        send_item(make_item(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 0, PMAX, 1));
        send_item(make_item(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX,
                            PMAX, 0, ONE_T - 1));
        send_item(make_item(100, -200, 300, -400, 500, -600, 700, -800,
                            1234, 4321, ONE_T + 1));
        send_item(make_item(-100, 200, -300, 400, -500, 600, -700, 800,
                            PMAX, 7, 2 * ONE_T - 1));
        send_item(make_item(4, -4, 0, 0, 0, 0, 0, 0, 1, 0, ONE_T / 2));
        send_item(make_item(-4, 4, 0, 0, 0, 0, 0, 0, 0, 3, ONE_T / 2));
        send_item(make_item(0, 0, 2, -2, 0, 0, 0, 0, 5, 6, ONE_T / 2));
        send_item(make_item(0, 0, 0, 0, -2, 2, 0, 0, PMAX, PMAX - 1, ONE_T / 2));
        send_item(make_item(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX,
                            PMAX, PMAX, ONE_T / 4));

        // Sender pauses here until the pipeline has emptied completely.
        drain_results();

        // Sender idles less than the receiver; one long receiver hold-off early on.
        hold_asks <= 1;
        send_random(RANDOM_ITEMS / 3);

        // Roles swapped: the sender is the slow side now.
        send_idle_pct = 50;
        recv_idle_pct <= 17;
        send_random(RANDOM_ITEMS / 3);

        // Back to back in both directions.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_points.errors == 0)
            $display("PASS cubic_bezier_point_eval_core");
        else
            $display("FAIL cubic_bezier_point_eval_core");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cbpe_pkg.sv
rtl/cbpe_lerp.sv
rtl/cubic_bezier_point_eval_core.sv
dv/cubic_bezier_point_eval_core_tb.sv
